[hw/rtl/isrc_pkg.sv]
`timescale 1ns / 1ps

package isrc_pkg;

  localparam logic [31:0] SRC_ADDR_RESET = 32'h0101_0101;

  // Byte offsets within the Ethernet frame
  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_VER_IHL  = 16'd14;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] POS_SRC_0    = 16'd26;
  localparam logic [15:0] POS_SRC_3    = 16'd29;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [3:0] IHL_MIN       = 4'd5;
  localparam logic [7:0] ETH_HDR_BYTES = 8'd14;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [7:0] TCP_CSUM_OFS = 8'd16;
  localparam logic [7:0] UDP_CSUM_OFS = 8'd6;
  localparam logic [7:0] TCP_HDR_BYTES = 8'd20;
  localparam logic [7:0] UDP_HDR_BYTES = 8'd8;

  // Patch decision for the byte being accepted
  typedef struct packed {
    logic        hdr_fix;  // rewrite IP checksum and source address
    logic        l4_fix;   // rewrite the L4 checksum (newest two bytes)
    logic [15:0] sum;      // patched checksum value
  } patch_t;

  // Incremental one's-complement update: ~(~hc + ~from + to)
  function automatic logic [15:0] csum_patch(input logic [15:0] hc,
                                             input logic [31:0] from,
                                             input logic [31:0] to);
    logic [18:0] s;
    logic [16:0] f1;
    logic [16:0] f2;
    s = {3'b000, ~hc} + {3'b000, ~from[31:16]} + {3'b000, ~from[15:0]}
      + {3'b000, to[31:16]} + {3'b000, to[15:0]};
    f1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
    f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
    return ~f2[15:0];
  endfunction

endpackage

[hw/rtl/isrc_if.sv]
`timescale 1ns / 1ps

interface isrc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] frame_length;
  logic        last_byte;

  modport source (output valid, data_byte, frame_length, last_byte, input ready);
  modport sink (input valid, data_byte, frame_length, last_byte, output ready);
endinterface

interface isrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink (input valid, out_byte, out_last, output ready);
endinterface

[hw/rtl/isrc_hdr.sv]
`timescale 1ns / 1ps

module isrc_hdr (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic [15:0]        frame_length,
  input  logic               last_byte,
  input  logic [15:0]        ip_csum,
  input  logic [31:0]        new_addr,
  output isrc_pkg::patch_t   patch
);

  logic [15:0] pos;
  logic [3:0]  ihl;
  logic [7:0]  proto;
  logic        rewrite;
  logic [31:0] old_addr;
  logic [7:0]  csum_hold;

  logic        rewrite_now;
  logic [3:0]  ihl_now;
  logic [7:0]  proto_now;
  logic [31:0] old_now;
  logic [7:0]  l4_ofs;
  logic [16:0] hdr_end;
  logic        is_tcp;
  logic        is_udp;
  logic        active;
  logic [7:0]  csum_hi_pos;
  logic [8:0]  csum_lo_pos;
  logic [16:0] l4_end;
  logic        l4_here;
  logic [15:0] hc;
  logic [15:0] nc;

  always_comb begin
    ihl_now   = (pos == isrc_pkg::POS_VER_IHL) ? data_byte[3:0] : ihl;
    proto_now = (pos == isrc_pkg::POS_PROTO) ? data_byte : proto;
    l4_ofs    = isrc_pkg::ETH_HDR_BYTES + {2'b00, ihl_now, 2'b00};
    hdr_end   = {9'd0, l4_ofs};

    case (pos)
      isrc_pkg::POS_ETYPE_HI: rewrite_now = (data_byte == isrc_pkg::ETYPE_IPV4_HI);
      isrc_pkg::POS_ETYPE_LO: rewrite_now = rewrite && (data_byte == isrc_pkg::ETYPE_IPV4_LO);
      isrc_pkg::POS_VER_IHL:  rewrite_now = rewrite && (ihl_now >= isrc_pkg::IHL_MIN)
                                          && ({1'b0, frame_length} >= hdr_end);
      default:                rewrite_now = rewrite;
    endcase

    old_now = ((pos >= isrc_pkg::POS_SRC_0) && (pos <= isrc_pkg::POS_SRC_3))
            ? {old_addr[23:0], data_byte} : old_addr;

    active = rewrite_now && (old_now != new_addr);
    is_tcp = (proto_now == isrc_pkg::PROTO_TCP);
    is_udp = (proto_now == isrc_pkg::PROTO_UDP);

    csum_hi_pos = l4_ofs + (is_udp ? isrc_pkg::UDP_CSUM_OFS : isrc_pkg::TCP_CSUM_OFS);
    csum_lo_pos = {1'b0, csum_hi_pos} + 9'd1;
    l4_end      = hdr_end + {9'd0, is_udp ? isrc_pkg::UDP_HDR_BYTES : isrc_pkg::TCP_HDR_BYTES};
    l4_here     = active && (is_tcp || is_udp) && (pos == {7'd0, csum_lo_pos})
                && (l4_end <= {1'b0, frame_length});

    patch.hdr_fix = active && (pos == isrc_pkg::POS_SRC_3);
    hc = patch.hdr_fix ? ip_csum : {csum_hold, data_byte};
    nc = isrc_pkg::csum_patch(hc, old_now, new_addr);
    // UDP: zero means "no checksum"; never emit zero as a computed value
    patch.l4_fix = l4_here && !(is_udp && (hc == 16'd0));
    patch.sum    = (is_udp && !patch.hdr_fix && (nc == 16'd0)) ? 16'hFFFF : nc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 16'd0;
      ihl       <= 4'd0;
      proto     <= 8'd0;
      rewrite   <= 1'b0;
      old_addr  <= 32'd0;
      csum_hold <= 8'd0;
    end else if (accept) begin
      if (last_byte) begin
        pos       <= 16'd0;
        ihl       <= 4'd0;
        proto     <= 8'd0;
        rewrite   <= 1'b0;
        old_addr  <= 32'd0;
        csum_hold <= 8'd0;
      end else begin
        if (pos != isrc_pkg::POS_MAX) begin
          pos <= pos + 16'd1;
        end
        ihl      <= ihl_now;
        proto    <= proto_now;
        rewrite  <= rewrite_now;
        old_addr <= old_now;
        if (active && (is_tcp || is_udp) && (pos == {8'd0, csum_hi_pos})) begin
          csum_hold <= data_byte;
        end
      end
    end
  end

endmodule

[hw/rtl/ipv4_source_rewrite_checksum.sv]
`timescale 1ns / 1ps

// IPv4 source rewrite: takes an Ethernet frame one byte per cycle on rx and
// sends the same bytes on tx, with the IPv4 source address replaced by the
// value in cfg_wr_data (big-endian) and the IP, TCP and UDP checksums
// patched incrementally. Frames that are not IPv4, have IHL below 5, or whose
// IP header does not fit in frame_length pass unchanged. A byte leaves once
// DELAY_BYTES newer bytes of its frame have arrived (the IP checksum sits
// ahead of the address it depends on) or once its frame has ended, so the
// tail of one frame drains while the next frame streams in. Throughput is
// one byte per cycle in both directions while tx is ready, with no gap
// between frames. With back-to-back input and tx ready, a byte passes
// through the byte queue and the output register to tx; after last_byte
// the held tail drains at one byte per cycle. The byte queue holds
// 2*DELAY_BYTES+2 bytes; rx.ready drops only when tx stalls long enough
// to fill it. Write the address register only while no frame is in flight.
module ipv4_source_rewrite_checksum #(
  parameter int DELAY_BYTES = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data,
  isrc_in_if.sink         rx,
  isrc_out_if.source      tx
);

  localparam int QDEPTH = 2 * DELAY_BYTES + 2;
  localparam int CNT_W  = $clog2(QDEPTH + 1);
  localparam int IDX_W  = $clog2(QDEPTH);

  // Replacement source address
  logic [31:0] new_addr;

  // Byte queue, entry 0 holds the newest byte
  logic [7:0]       q      [QDEPTH];
  logic [7:0]       q_next [QDEPTH];
  logic [QDEPTH-1:0] lastq;
  logic [QDEPTH-1:0] lastq_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  // Oldest entries that belong to frames already ended
  logic [CNT_W-1:0] done;
  logic [CNT_W-1:0] done_next;

  logic [IDX_W-1:0] head_idx;
  logic             head_ok;
  logic             accept;
  logic             deq;

  // Output register
  logic       ov;
  logic [7:0] ob;
  logic       ol;

  isrc_pkg::patch_t patch;

  always_ff @(posedge clk) begin
    if (rst) begin
      new_addr <= isrc_pkg::SRC_ADDR_RESET;
    end else if (cfg_wr_en) begin
      new_addr <= cfg_wr_data;
    end
  end

  assign rx.ready = (count < CNT_W'(QDEPTH));
  assign accept   = rx.valid && rx.ready;

  // Header tracking and checksum math; the IP checksum sits at ages 4 and 5
  // once the last address byte is shifted in, i.e. entries 4 and 3 now.
  isrc_hdr u_hdr (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (rx.data_byte),
    .frame_length (rx.frame_length),
    .last_byte    (rx.last_byte),
    .ip_csum      ({q[4], q[3]}),
    .new_addr     (new_addr),
    .patch        (patch)
  );

  // A head byte is final when its frame ended or it can no longer be patched
  assign head_idx = IDX_W'(count - CNT_W'(1));
  assign head_ok  = (count != '0) && ((done != '0) || (count > CNT_W'(DELAY_BYTES)));
  assign deq      = head_ok && (!ov || tx.ready);

  always_comb begin
    q_next     = q;
    lastq_next = lastq;
    if (accept) begin
      for (int k = QDEPTH - 1; k > 0; k--) begin
        q_next[k]     = q[k-1];
        lastq_next[k] = lastq[k-1];
      end
      q_next[0]     = rx.data_byte;
      lastq_next[0] = rx.last_byte;
      // Overwrite IP checksum and source address in place
      if (patch.hdr_fix) begin
        q_next[5] = patch.sum[15:8];
        q_next[4] = patch.sum[7:0];
        q_next[3] = new_addr[31:24];
        q_next[2] = new_addr[23:16];
        q_next[1] = new_addr[15:8];
        q_next[0] = new_addr[7:0];
      end
      // Overwrite the L4 checksum, whose low byte is arriving now
      if (patch.l4_fix) begin
        q_next[1] = patch.sum[15:8];
        q_next[0] = patch.sum[7:0];
      end
    end

    count_next = count + CNT_W'(accept) - CNT_W'(deq);
    if (accept && rx.last_byte) begin
      done_next = count_next;
    end else if (deq && (done != '0)) begin
      done_next = done - CNT_W'(1);
    end else begin
      done_next = done;
    end
  end

  always_ff @(posedge clk) begin
    q     <= q_next;
    lastq <= lastq_next;
    if (rst) begin
      count <= '0;
      done  <= '0;
    end else begin
      count <= count_next;
      done  <= done_next;
    end
  end

  // Output stage: load from the head whenever it is final and the slot frees
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (deq) begin
      ov <= 1'b1;
    end else if (tx.ready) begin
      ov <= 1'b0;
    end
    if (deq) begin
      ob <= q[head_idx];
      ol <= lastq[head_idx];
    end
  end

  assign tx.valid    = ov;
  assign tx.out_byte = ob;
  assign tx.out_last = ol;

endmodule
